// ===== rtl/bmsi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmsi_pkg: shared types and constants
// bank mapper with scanline interrupt: payload structs, codes, controller states
// ----------------------------------------------------------------------------
package bmsi_pkg;

  localparam int unsigned PrgAddrBits = 21;
  localparam int unsigned ChrAddrBits = 18;

  localparam logic [2:0] ModeCpuRead  = 3'd0;
  localparam logic [2:0] ModeCpuWrite = 3'd1;
  localparam logic [2:0] ModePpuRead  = 3'd2;
  localparam logic [2:0] ModePpuWrite = 3'd3;
  localparam logic [2:0] ModeTick     = 3'd4;

  localparam logic [1:0] TgtNone   = 2'd0;
  localparam logic [1:0] TgtPrgRam = 2'd1;
  localparam logic [1:0] TgtPrgRom = 2'd2;
  localparam logic [1:0] TgtChr    = 2'd3;

  localparam logic [1:0] CfgPrgCount = 2'd0;
  localparam logic [1:0] CfgChrCount = 2'd1;
  localparam logic [1:0] CfgRamBytes = 2'd2;
  localparam logic [1:0] CfgChrWr    = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] mem_address;
    logic        mem_write;
    logic        irq_line;
    logic        mirror_horizontal;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FORM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic upd;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/bank_mapper_with_scanline_irq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq: mmc3-style bank mapper
// Each bus access or scanline tick is processed in steps after it transfers in:
// a serial unit reduces the bank number modulo the bank count and the ram
// offset modulo the ram size, one bit a cycle, then the address is formed and
// mapper and irq state are updated before the result is offered. One item is
// in flight at a time; a new item transfers in the same cycle its predecessor's
// result does.
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire bmsi_pkg::in_item_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output bmsi_pkg::out_item_t out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [13:0] cfg_data
);

  bmsi_pkg::ctrl_cmd_t cmd;
  logic div_last;

  bmsi_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .div_last(div_last), .cmd(cmd)
  );

  bmsi_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .div_last(div_last), .out_item(out_data)
  );

  a_load_needs_transfer: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_valid && in_ready)) else $error("load without transfer");
  a_exec_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $past(cmd.load || cmd.exec)) else $error("exec without load");
  a_result_after_upd: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |=> out_valid) else $error("result missing");

endmodule
`default_nettype wire

// ===== rtl/bmsi_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmsi_ctrl: sequencing controller
// takes one item, lets the datapath reduce and update, then offers the result
// ----------------------------------------------------------------------------
module bmsi_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire logic div_last,
  output bmsi_pkg::ctrl_cmd_t cmd
);

  bmsi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= bmsi_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    out_valid = 1'b0;
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    cmd.upd = 1'b0;
    case (state)
      bmsi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = bmsi_pkg::ST_CALC;
        end
      end
      bmsi_pkg::ST_CALC: begin
        cmd.exec = 1'b1;
        if (div_last) state_next = bmsi_pkg::ST_FORM;
      end
      bmsi_pkg::ST_FORM: begin
        cmd.upd = 1'b1;
        state_next = bmsi_pkg::ST_OUT;
      end
      bmsi_pkg::ST_OUT: begin
        out_valid = 1'b1;
        // next item may enter in the same cycle the result transfers
        in_ready = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load = 1'b1;
            state_next = bmsi_pkg::ST_CALC;
          end else begin
            state_next = bmsi_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = bmsi_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/bmsi_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmsi_datapath: mapper registers and address translation
// a serial unit reduces bank and ram offset, then the address is formed
// ----------------------------------------------------------------------------
module bmsi_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire bmsi_pkg::ctrl_cmd_t cmd,
  input  wire bmsi_pkg::in_item_t  in_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [13:0] cfg_data,
  output logic             div_last,
  output bmsi_pkg::out_item_t out_item
);

  logic [8:0]  prg_count;
  logic [8:0]  chr_count;
  logic [13:0] ram_bytes;
  logic        chr_wr;

  logic [2:0] sel_reg;
  logic       prg_swap;
  logic       chr_swap;
  logic [7:0] banks [8];
  logic       mirror;
  logic [7:0] irq_reload;
  logic [7:0] irq_count;
  logic       irq_reload_pend;
  logic       irq_en;
  logic       irq_pend;

  // latched item
  bmsi_pkg::in_item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_count <= 9'd64;
      chr_count <= 9'd256;
      ram_bytes <= 14'd8192;
      chr_wr <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx)
        bmsi_pkg::CfgPrgCount: prg_count <= cfg_data[8:0];
        bmsi_pkg::CfgChrCount: chr_count <= cfg_data[8:0];
        bmsi_pkg::CfgRamBytes: ram_bytes <= cfg_data;
        bmsi_pkg::CfgChrWr:    chr_wr <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic cpu;
  logic ppu;
  always_comb begin
    cpu = item.mode == bmsi_pkg::ModeCpuRead || item.mode == bmsi_pkg::ModeCpuWrite;
    ppu = item.mode == bmsi_pkg::ModePpuRead || item.mode == bmsi_pkg::ModePpuWrite;
  end

  // bank selection from the latched item
  logic [1:0] pwin;
  logic [2:0] cwin;
  logic [8:0] sec_last;
  logic [7:0] sel_bank;
  logic       sel_fixed;
  logic [8:0] fixed_bank;
  always_comb begin
    pwin = item.address[14:13];
    cwin = item.address[12:10] ^ {chr_swap, 2'b00};
    sec_last = (prg_count >= 9'd2) ? prg_count - 9'd2 : 9'd0;
    sel_bank = 8'd0;
    sel_fixed = 1'b0;
    fixed_bank = 9'd0;
    if (ppu) begin
      if (!cwin[2]) sel_bank = {banks[{2'b00, cwin[1]}][7:1], cwin[0]};
      else          sel_bank = banks[cwin - 3'd2];
    end else begin
      case (pwin)
        2'd0: begin
          sel_fixed = prg_swap;
          fixed_bank = sec_last;
          sel_bank = banks[6];
        end
        2'd1: sel_bank = banks[7];
        2'd2: begin
          sel_fixed = !prg_swap;
          fixed_bank = sec_last;
          sel_bank = banks[6];
        end
        default: begin
          sel_fixed = 1'b1;
          fixed_bank = prg_count - 9'd1;
        end
      endcase
    end
  end

  // restoring remainder, one bit a cycle msb first: 13 steps for the ram
  // offset, the bank takes part in the last 8
  logic [3:0]  bit_idx;
  logic [8:0]  brem;
  logic [13:0] rrem;
  logic [8:0]  modc;
  logic [9:0]  btrial;
  logic [9:0]  bdiff;
  logic [8:0]  brem_next;
  logic [14:0] rtrial;
  logic [14:0] rdiff;
  logic [13:0] rrem_next;
  always_comb begin
    modc = ppu ? chr_count : prg_count;
    btrial = {brem, sel_bank[bit_idx[2:0]]};
    bdiff = btrial - {1'b0, modc};
    brem_next = (btrial >= {1'b0, modc}) ? bdiff[8:0] : btrial[8:0];
    rtrial = {rrem, item.address[bit_idx]};
    rdiff = rtrial - {1'b0, ram_bytes};
    rrem_next = (rtrial >= {1'b0, ram_bytes}) ? rdiff[13:0] : rtrial[13:0];
    div_last = (bit_idx == 4'd0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      bit_idx <= 4'd12;
      brem <= 9'd0;
      rrem <= 14'd0;
    end else if (cmd.exec) begin
      rrem <= rrem_next;
      if (bit_idx < 4'd8) brem <= brem_next;
      bit_idx <= bit_idx - 4'd1;
    end
  end

  // form result and update state
  logic [8:0]  bank_val;
  logic [21:0] prg_full;
  logic [18:0] chr_full;
  logic [bmsi_pkg::PrgAddrBits-1:0] prg_addr;
  logic [bmsi_pkg::ChrAddrBits-1:0] chr_addr;
  always_comb begin
    bank_val = sel_fixed ? fixed_bank : brem;
    prg_full = {bank_val, item.address[12:0]};
    chr_full = {bank_val, item.address[9:0]};
    prg_addr = prg_full[bmsi_pkg::PrgAddrBits-1:0];
    chr_addr = chr_full[bmsi_pkg::ChrAddrBits-1:0];
  end

  logic       upd;
  logic [7:0] cnt_new;
  always_comb begin
    upd = cmd.upd;
    cnt_new = (irq_count == 8'd0 || irq_reload_pend) ? irq_reload : irq_count - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_reg <= 3'd0;
      prg_swap <= 1'b0;
      chr_swap <= 1'b0;
      for (int i = 0; i < 8; i++) banks[i] <= 8'd0;
      mirror <= 1'b0;
      irq_reload <= 8'd0;
      irq_count <= 8'd0;
      irq_reload_pend <= 1'b0;
      irq_en <= 1'b0;
      irq_pend <= 1'b0;
    end else if (upd) begin
      if (item.mode == bmsi_pkg::ModeCpuWrite && item.address[15]) begin
        case (item.address[14:13])
          2'd0: begin
            if (!item.address[0]) begin
              sel_reg <= item.write_data[2:0];
              prg_swap <= item.write_data[6];
              chr_swap <= item.write_data[7];
            end else begin
              banks[sel_reg] <= item.write_data;
            end
          end
          2'd1: if (!item.address[0]) mirror <= item.write_data[0];
          2'd2: begin
            if (!item.address[0]) irq_reload <= item.write_data;
            else irq_reload_pend <= 1'b1;
          end
          default: begin
            if (!item.address[0]) begin
              irq_en <= 1'b0;
              irq_pend <= 1'b0;
            end else begin
              irq_en <= 1'b1;
            end
          end
        endcase
      end else if (item.mode == bmsi_pkg::ModeTick) begin
        irq_count <= cnt_new;
        irq_reload_pend <= 1'b0;
        if (cnt_new == 8'd0 && irq_en) irq_pend <= 1'b1;
      end
    end
  end

  logic [1:0]  res_target;
  logic [20:0] res_addr;
  logic        res_write;
  always_ff @(posedge clk) begin
    if (upd) begin
      res_target <= bmsi_pkg::TgtNone;
      res_addr <= 21'd0;
      res_write <= 1'b0;
      if (cpu && item.address[15:13] == 3'b011) begin
        if (ram_bytes != 14'd0) begin
          res_target <= bmsi_pkg::TgtPrgRam;
          res_addr <= {8'd0, rrem[12:0]};
          res_write <= item.mode[0];
        end
      end else if (item.mode == bmsi_pkg::ModeCpuRead && item.address[15]) begin
        if (prg_count != 9'd0) begin
          res_target <= bmsi_pkg::TgtPrgRom;
          res_addr <= 21'(prg_addr);
        end
      end else if (ppu && (item.mode == bmsi_pkg::ModePpuRead || chr_wr)
                   && chr_count != 9'd0) begin
        res_target <= bmsi_pkg::TgtChr;
        res_addr <= 21'(chr_addr);
        res_write <= item.mode[0];
      end
    end
  end

  always_comb begin
    out_item.target = res_target;
    out_item.mem_address = res_addr;
    out_item.mem_write = res_write;
    out_item.irq_line = irq_pend;
    out_item.mirror_horizontal = mirror;
  end

endmodule
`default_nettype wire

// ===== tb/bank_mapper_with_scanline_irq_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_test: self-checking bench for the mmc3 mapper
// A queue-fed driver offers bus accesses and scanline ticks, a monitor takes
// results, and a local mapper model predicts target, address, write flag, irq and mirror state.
// ----------------------------------------------------------------------------
module bank_mapper_with_scanline_irq_test;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bmsi_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bmsi_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [13:0] cfg_data = '0;

  bank_mapper_with_scanline_irq dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mapper model state
  logic [8:0] prg_banks, chr_banks;
  logic [13:0] ram_size;
  logic chr_ram;
  logic [2:0] sel_reg;
  logic prg_mode, chr_mode, mirror;
  logic [7:0] banks [8];
  logic [7:0] irq_latch, irq_counter;
  logic irq_reload, irq_en, irq_flag;

  bmsi_pkg::in_item_t pending_accesses[$];
  bmsi_pkg::out_item_t expected_results[$];
  int errors = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  bit done = 1'b0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch #%0d %s: got %0h expected %0h", checked, what, got, want);
    errors++;
  endtask

  function automatic int unsigned prg_bank(input logic [1:0] win);
    int unsigned n, r6, r7, second;
    n = prg_banks;
    r6 = banks[6] % n;
    r7 = banks[7] % n;
    second = (n >= 2) ? n - 2 : 0;
    case (win)
      2'd0: return prg_mode ? second : r6;
      2'd1: return r7;
      2'd2: return prg_mode ? r6 : second;
      default: return n - 1;
    endcase
  endfunction

  function automatic int unsigned chr_bank(input logic [2:0] win);
    logic [2:0] w;
    int unsigned b;
    w = win ^ {chr_mode, 2'b00};
    if (w < 4) b = (banks[w >> 1] & 8'hFE) | w[0];
    else b = banks[w - 2];
    return b % chr_banks;
  endfunction

  function automatic bmsi_pkg::out_item_t map_access(input bmsi_pkg::in_item_t it);
    bmsi_pkg::out_item_t r;
    logic [15:0] off;
    logic odd;
    int unsigned a;
    r = '0;
    odd = it.address[0];
    if (it.mode == bmsi_pkg::ModeCpuRead || it.mode == bmsi_pkg::ModeCpuWrite) begin
      if (it.address >= 16'h6000 && it.address < 16'h8000) begin
        if (ram_size != 0) begin
          r.target = bmsi_pkg::TgtPrgRam;
          r.mem_address = (it.address - 16'h6000) % ram_size;
          r.mem_write = (it.mode == bmsi_pkg::ModeCpuWrite);
        end
      end else if (it.address >= 16'h8000) begin
        if (it.mode == bmsi_pkg::ModeCpuWrite) begin
          if (it.address <= 16'h9FFF) begin
            if (!odd) begin
              sel_reg = it.write_data[2:0];
              prg_mode = it.write_data[6];
              chr_mode = it.write_data[7];
            end else banks[sel_reg] = it.write_data;
          end else if (it.address <= 16'hBFFF) begin
            if (!odd) mirror = it.write_data[0];
          end else if (it.address <= 16'hDFFF) begin
            if (!odd) irq_latch = it.write_data;
            else irq_reload = 1'b1;
          end else begin
            if (!odd) begin
              irq_en = 1'b0;
              irq_flag = 1'b0;
            end else irq_en = 1'b1;
          end
        end else if (prg_banks != 0) begin
          off = it.address - 16'h8000;
          a = (prg_bank(off[14:13]) << 13) | off[12:0];
          r.target = bmsi_pkg::TgtPrgRom;
          r.mem_address = a[20:0];
        end
      end
    end else if (it.mode == bmsi_pkg::ModePpuRead || it.mode == bmsi_pkg::ModePpuWrite) begin
      if ((it.mode == bmsi_pkg::ModePpuRead || chr_ram) && chr_banks != 0) begin
        a = (chr_bank(it.address[12:10]) << 10) | it.address[9:0];
        r.target = bmsi_pkg::TgtChr;
        r.mem_address = a & 32'h3FFFF;
        r.mem_write = (it.mode == bmsi_pkg::ModePpuWrite);
      end
    end else if (it.mode == bmsi_pkg::ModeTick) begin
      if (irq_counter == 0 || irq_reload) begin
        irq_counter = irq_latch;
        irq_reload = 1'b0;
      end else irq_counter = irq_counter - 8'd1;
      if (irq_counter == 0 && irq_en) irq_flag = 1'b1;
    end
    r.irq_line = irq_flag;
    r.mirror_horizontal = mirror;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_results.push_back(map_access(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_accesses.pop_front();
          in_valid <= 1'b1;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    bmsi_pkg::out_item_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transfer", out_data, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.target !== want.target)
            report_mismatch("target", out_data.target, want.target);
          if (out_data.mem_address !== want.mem_address)
            report_mismatch("mem_address", out_data.mem_address, want.mem_address);
          if (out_data.mem_write !== want.mem_write)
            report_mismatch("mem_write", out_data.mem_write, want.mem_write);
          if (out_data.irq_line !== want.irq_line)
            report_mismatch("irq_line", out_data.irq_line, want.irq_line);
          if (out_data.mirror_horizontal !== want.mirror_horizontal)
            report_mismatch("mirror", out_data.mirror_horizontal, want.mirror_horizontal);
        end
        checked++;
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst && !done) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("bank_mapper_with_scanline_irq verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[13:0];
    case (idx)
      bmsi_pkg::CfgPrgCount: prg_banks = val[8:0];
      bmsi_pkg::CfgChrCount: chr_banks = val[8:0];
      bmsi_pkg::CfgRamBytes: ram_size = val[13:0];
      default: chr_ram = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_access(input logic [2:0] m, input logic [15:0] a, input logic [7:0] d);
    bmsi_pkg::in_item_t it;
    it.mode = m;
    it.address = a;
    it.write_data = d;
    pending_accesses.push_back(it);
  endtask

  task automatic drain;
    while (pending_accesses.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // random mapper traffic: bank setup, irq programming, accesses, ticks, arbitrary modes
  task automatic push_random(input int count);
    int k;
    logic [2:0] m;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: begin
          push_access(bmsi_pkg::ModeCpuWrite,
                      16'h8000 | ($urandom_range(16'h1FFF) & 16'hFFFE), $urandom_range(255));
          push_access(bmsi_pkg::ModeCpuWrite, 16'h8001 | $urandom_range(16'h1FFF),
                      $urandom_range(255));
        end
        1: push_access(bmsi_pkg::ModeCpuWrite, 16'h8000 + $urandom_range(16'h7FFF),
                       $urandom_range(255));
        2: begin
          push_access(bmsi_pkg::ModeCpuWrite,
                      16'hC000 | ($urandom_range(16'h1FFF) & 16'hFFFE), $urandom_range(8));
          push_access(bmsi_pkg::ModeCpuWrite, 16'hC001, $urandom_range(255));
          push_access(bmsi_pkg::ModeCpuWrite, 16'hE001, $urandom_range(255));
        end
        3, 4: push_access(bmsi_pkg::ModeTick, $urandom_range(16'hFFFF), $urandom_range(255));
        5: begin
          m = $urandom_range(7);
          push_access(m, $urandom_range(16'hFFFF), $urandom_range(255));
        end
        6: push_access($urandom_range(1), 16'h6000 + $urandom_range(16'h1FFF),
                       $urandom_range(255));
        7: push_access(bmsi_pkg::ModeCpuRead, 16'h8000 + $urandom_range(16'h7FFF),
                       $urandom_range(255));
        default: push_access(bmsi_pkg::ModePpuRead + $urandom_range(1),
                             $urandom_range(16'hFFFF), $urandom_range(255));
      endcase
    end
  endtask

  initial begin
    int p;
    int unsigned prg_set [5] = '{64, 1, 0, 256, 3};
    int unsigned chr_set [5] = '{256, 0, 1, 255, 7};
    int unsigned ram_set [5] = '{8192, 0, 1, 8191, 3000};
    prg_banks = 9'd64; chr_banks = 9'd256; ram_size = 14'd8192; chr_ram = 1'b0;
    sel_reg = '0; prg_mode = 0; chr_mode = 0; mirror = 0;
    foreach (banks[i]) banks[i] = '0;
    irq_latch = '0; irq_counter = '0; irq_reload = 0; irq_en = 0; irq_flag = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: every mode, field extremes, register regions, irq at zero
    push_access(bmsi_pkg::ModeCpuRead, 16'h0000, 8'h00);
    push_access(bmsi_pkg::ModeCpuRead, 16'h5FFF, 8'hFF);
    push_access(bmsi_pkg::ModeCpuWrite, 16'h7FFF, 8'hFF);
    push_access(bmsi_pkg::ModeCpuWrite, 16'h8000, 8'hC6);
    push_access(bmsi_pkg::ModeCpuWrite, 16'h8001, 8'hFF);
    push_access(bmsi_pkg::ModeCpuWrite, 16'h8000, 8'h07);
    push_access(bmsi_pkg::ModeCpuWrite, 16'h9FFF, 8'h3F);
    push_access(bmsi_pkg::ModeCpuRead, 16'h8000, 8'h00);
    push_access(bmsi_pkg::ModeCpuRead, 16'hFFFF, 8'h00);
    push_access(bmsi_pkg::ModeCpuWrite, 16'hA000, 8'h01);
    push_access(bmsi_pkg::ModeCpuWrite, 16'hA001, 8'h00);
    push_access(bmsi_pkg::ModePpuRead, 16'hFFFF, 8'h00);
    push_access(bmsi_pkg::ModePpuWrite, 16'h0000, 8'hAA);
    push_access(bmsi_pkg::ModeCpuWrite, 16'hC000, 8'h02);
    push_access(bmsi_pkg::ModeCpuWrite, 16'hE001, 8'h00);
    push_access(bmsi_pkg::ModeTick, 16'h0000, 8'h00);
    push_access(bmsi_pkg::ModeTick, 16'h0000, 8'h00);
    push_access(bmsi_pkg::ModeTick, 16'h0000, 8'h00);
    push_access(bmsi_pkg::ModeCpuWrite, 16'hC001, 8'h00);
    push_access(bmsi_pkg::ModeTick, 16'h0000, 8'h00);
    push_access(bmsi_pkg::ModeCpuWrite, 16'hE000, 8'h00);
    push_access(3'd5, 16'hFFFF, 8'hFF);
    push_access(3'd7, 16'h8000, 8'h55);
    drain();

    for (p = 0; p < 5; p++) begin
      write_reg(bmsi_pkg::CfgPrgCount, prg_set[p]);
      write_reg(bmsi_pkg::CfgChrCount, chr_set[p]);
      write_reg(bmsi_pkg::CfgRamBytes, ram_set[p]);
      write_reg(bmsi_pkg::CfgChrWr, p % 2);
      case (p)
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        3: begin send_idle_pct = 35; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      push_random(142);
      if (p == 4) begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    done = 1'b1;
    $display("covered %0d results over five bank/ram configurations", checked);
    $display("with idle, stall and back-pressure phases, %0d mismatches", errors);
    if (errors == 0) $display("bank_mapper_with_scanline_irq verification clean");
    else $display("bank_mapper_with_scanline_irq verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/bmsi_pkg.sv
rtl/bmsi_ctrl.sv
rtl/bmsi_datapath.sv
rtl/bank_mapper_with_scanline_irq.sv
tb/bank_mapper_with_scanline_irq_test.sv
